>>> rtl/stimulus_table_sequencer_defines.svh
// Assertion macros shared by the stimulus table sequencer RTL.
`ifndef STIMULUS_TABLE_SEQUENCER_DEFINES_SVH
`define STIMULUS_TABLE_SEQUENCER_DEFINES_SVH

`ifndef SYNTH

// Checks that cons holds in the same cycle as ante.
`define STSQ_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Checks that cons holds in the cycle after ante.
`define STSQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define STSQ_ASSERT_SAME(label, clk, rstn, ante, cons)
`define STSQ_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

>>> rtl/stsq_pkg.sv
// Shared widths and codes of the stimulus table sequencer.
package stsq_pkg;

    localparam int DRIVE_W   = 10;
    localparam int INDEX_W   = 7;
    localparam int PERIOD_W  = 8;
    localparam int LENGTH_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 2'd2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef logic [DRIVE_W-1:0] drive_t;

endpackage

>>> rtl/stsq_table.sv
// Waveform table RAM: one write port and one registered read port.
module stsq_table #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    input  stsq_pkg::drive_t               wr_data,
    input  logic                           rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    output stsq_pkg::drive_t               rd_data
);
    import stsq_pkg::*;

    drive_t mem [TABLE_DEPTH];
    drive_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds while no read is issued, which lets the caller stall.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/stimulus_table_sequencer.sv
// Stimulus table sequencer: plays back a table of drive codes on tick beats.
// One input beat is taken every clock cycle while the read stage is not stalled.
// A write beat stores its code through the table RAM write port in the cycle it
// is accepted; a tick beat updates the position and counter at once and, when it
// moves to a new entry, reads that entry through the single RAM read port. Its
// result, if any, is decided in the next cycle from the registered read data and
// lands in the output register once that is free. The code of the current
// entry is kept in a register, with forwarding from the read data and from later
// writes, so each tick needs only one RAM read. The table is not cleared after
// reset and needs no clearing pass; entries must be written before they play.
module stimulus_table_sequencer #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [stsq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stsq_pkg::CFG_DAT_W-1:0]  cfg_data,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // entry_index[6:0], entry_value[16:7]
    input  logic [0:0]                      s_tuser,   // func[0]
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // drive_code[9:0]
    output logic [0:0]                      m_tuser    // stopped[0]
);
    import stsq_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    typedef enum logic [2:0] {
        KIND_FIRST   = 3'b001,
        KIND_ADVANCE = 3'b010,
        KIND_STOP    = 3'b100
    } kind_t;

    // Configuration.
    logic [PERIOD_W-1:0] step_period_reg;
    logic                loop_mode_reg;
    logic [LENGTH_W-1:0] table_length_reg;

    // Playback state.
    logic [AW-1:0]       pos_reg, pos_next;
    logic [PERIOD_W-1:0] cnt_reg, cnt_next;
    logic                enable_reg, enable_next;
    logic                started_reg, started_next;
    drive_t              cur_code_reg, cur_code_next;

    // Read-data stage.
    logic   b_valid_reg, b_valid_next;
    kind_t  b_kind_reg, b_kind_next;
    drive_t b_old_reg, b_old_next;

    // Output register.
    logic   out_valid_reg;
    drive_t out_code_reg;
    logic   out_stopped_reg;

    logic          s_fire;
    logic          in_func;
    logic [INDEX_W-1:0] in_index;
    drive_t        in_value;
    logic          wr_ok;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    drive_t        rd_data;
    logic [AW-1:0] last_idx;
    logic          b_load;
    logic          b_emit;
    drive_t        b_code;
    logic          b_stall;
    drive_t        cur_eff;

    assign in_func  = s_tuser[0];
    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_value = s_tdata[INDEX_W+DRIVE_W-1:INDEX_W];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_period_reg  <= PERIOD_W'(1);
            loop_mode_reg    <= 1'b0;
            table_length_reg <= LENGTH_W'(128);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_STEP_PERIOD:  step_period_reg  <= cfg_data;
                CFG_LOOP_MODE:    loop_mode_reg    <= cfg_data[0];
                CFG_TABLE_LENGTH: table_length_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Last entry in use, with the length clamped to the table.
    always_comb begin
        if (table_length_reg == '0) begin
            last_idx = '0;
        end else if (int'(table_length_reg) > TABLE_DEPTH) begin
            last_idx = AW'(TABLE_DEPTH - 1);
        end else begin
            last_idx = AW'(table_length_reg - LENGTH_W'(1));
        end
    end

    assign b_load = b_valid_reg && (b_kind_reg != KIND_STOP);

    always_comb begin
        b_emit = 1'b0;
        b_code = rd_data;
        unique case (b_kind_reg)
            KIND_FIRST:   b_emit = (rd_data != '0);
            KIND_ADVANCE: b_emit = (rd_data != b_old_reg);
            KIND_STOP: begin
                b_emit = 1'b1;
                b_code = '0;
            end
            default: b_emit = 1'b0;
        endcase
    end

    assign b_stall  = b_valid_reg && b_emit && out_valid_reg && !m_tready;
    assign s_tready = !b_stall;
    assign s_fire   = s_tvalid && s_tready;

    // The entry just read is newer than the register while a load sits in stage B.
    assign cur_eff = b_load ? rd_data : cur_code_reg;

    assign wr_ok   = (int'(in_index) < TABLE_DEPTH);
    assign wr_addr = AW'(in_index);

    always_comb begin
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        enable_next   = enable_reg;
        started_next  = started_reg;
        b_valid_next  = b_stall;
        b_kind_next   = b_kind_reg;
        b_old_next    = b_old_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        cur_code_next = cur_code_reg;

        if (b_load && !b_stall) begin
            cur_code_next = rd_data;
        end

        if (s_fire) begin
            if (in_func == FUNC_WRITE) begin
                if (wr_ok) begin
                    if (in_value != '0) begin
                        enable_next = 1'b1;
                    end
                    if (wr_addr == pos_reg) begin
                        cur_code_next = in_value;
                    end
                end
            end else if (!started_reg) begin
                started_next = 1'b1;
                if (enable_reg) begin
                    pos_next     = '0;
                    cnt_next     = PERIOD_W'(1);
                    rd_en        = 1'b1;
                    rd_addr      = '0;
                    b_valid_next = 1'b1;
                    b_kind_next  = KIND_FIRST;
                end
            end else if (enable_reg) begin
                if (cnt_reg != step_period_reg) begin
                    cnt_next = cnt_reg + PERIOD_W'(1);
                end else begin
                    cnt_next     = '0;
                    b_valid_next = 1'b1;
                    b_old_next   = cur_eff;
                    if (pos_reg >= last_idx) begin
                        if (loop_mode_reg) begin
                            pos_next    = '0;
                            rd_en       = 1'b1;
                            rd_addr     = '0;
                            b_kind_next = KIND_ADVANCE;
                        end else begin
                            enable_next = 1'b0;
                            b_kind_next = KIND_STOP;
                        end
                    end else begin
                        pos_next    = pos_reg + AW'(1);
                        rd_en       = 1'b1;
                        rd_addr     = pos_reg + AW'(1);
                        b_kind_next = KIND_ADVANCE;
                    end
                end
            end
        end
    end

    stsq_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (s_fire && (in_func == FUNC_WRITE) && wr_ok),
        .wr_addr (wr_addr),
        .wr_data (in_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            cnt_reg     <= '0;
            enable_reg  <= 1'b0;
            started_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            b_kind_reg  <= KIND_FIRST;
        end else begin
            pos_reg     <= pos_next;
            cnt_reg     <= cnt_next;
            enable_reg  <= enable_next;
            started_reg <= started_next;
            b_valid_reg <= b_valid_next;
            b_kind_reg  <= b_kind_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_code_reg <= cur_code_next;
        b_old_reg    <= b_old_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (b_valid_reg && b_emit && !b_stall) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_valid_reg && b_emit && !b_stall) begin
            out_code_reg    <= b_code;
            out_stopped_reg <= (b_kind_reg == KIND_STOP);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16 - DRIVE_W){1'b0}}, out_code_reg};
    assign m_tuser  = out_stopped_reg;

`include "stimulus_table_sequencer_defines.svh"

    // A stalled read stage keeps its beat and its read data.
    `STSQ_ASSERT_NEXT(a_stall_holds, aclk, aresetn, b_stall, b_valid_reg && $stable(rd_data))
    // A stop result always drives zero.
    `STSQ_ASSERT_SAME(a_stop_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == 16'd0)
    // Once playback has started it never returns to the unstarted state.
    `STSQ_ASSERT_NEXT(a_started_sticky, aclk, aresetn, started_reg, started_reg)

endmodule
